/* sv/xml_entity_unescaper_top_assert.svh */
// assertion macros for the xml entity unescaper top level
`ifndef XML_ENTITY_UNESCAPER_TOP_ASSERT_SVH
`define XML_ENTITY_UNESCAPER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define XEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define XEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/xeu_pkg.sv */
// shared types, constants and lookup functions of the xml entity unescaper
`default_nettype none

package xeu_pkg;

  // results one input word can cause, and the count width that holds that number
  localparam int XEU_MAX_RES = 6;
  localparam int XEU_CNT_W   = $clog2(XEU_MAX_RES + 1);

  // job queue between front and back end, depth a power of two
  localparam int XEU_QDEPTH = 4;
  localparam int XEU_QPTR_W = $clog2(XEU_QDEPTH);
  localparam int XEU_QCNT_W = $clog2(XEU_QDEPTH + 1);

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_SEMI = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  // characters
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_P    = 8'h70;

  // named reference selectors
  localparam logic [2:0] PAT_AMP  = 3'd0;
  localparam logic [2:0] PAT_APOS = 3'd1;
  localparam logic [2:0] PAT_GT   = 3'd2;
  localparam logic [2:0] PAT_LT   = 3'd3;
  localparam logic [2:0] PAT_QUOT = 3'd4;

  // utf-8 encoding constants
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
  localparam logic [20:0] CP_LIM1    = 21'h00080;
  localparam logic [20:0] CP_LIM2    = 21'h00800;
  localparam logic [20:0] CP_LIM3    = 21'h10000;
  localparam logic [24:0] CODE_LIMIT = 25'h0110000;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       done;
    logic [1:0] err;
  } xeu_res_t;

  // all results of one input word
  typedef struct packed {
    logic [XEU_CNT_W-1:0]         cnt;
    xeu_res_t [XEU_MAX_RES-1:0]   ent;
  } xeu_job_t;

  function automatic xeu_res_t mk_res(input logic [7:0] data, input logic byte_ok,
                                      input logic done, input logic [1:0] err);
    xeu_res_t r;
    r.data    = byte_ok ? data : 8'h00;
    r.byte_ok = byte_ok;
    r.done    = done;
    r.err     = err;
    return r;
  endfunction

  // letter idx of named reference p, zero past its end
  function automatic logic [7:0] pat_text(input logic [2:0] p, input logic [2:0] idx);
    logic [39:0] row;
    case (p)
      PAT_AMP:  row = {8'h00, CH_SEMI, CH_P, 8'h6D, CH_A};
      PAT_APOS: row = {CH_SEMI, 8'h73, 8'h6F, CH_P, CH_A};
      PAT_GT:   row = {8'h00, 8'h00, CH_SEMI, 8'h74, CH_G};
      PAT_LT:   row = {8'h00, 8'h00, CH_SEMI, 8'h74, CH_L};
      PAT_QUOT: row = {CH_SEMI, 8'h74, 8'h6F, 8'h75, CH_Q};
      default:  row = '0;
    endcase
    if (idx > 3'd4) return 8'h00;
    return row[idx*8 +: 8];
  endfunction

  function automatic logic [7:0] pat_char(input logic [2:0] p);
    case (p)
      PAT_AMP:  return CH_AMP;
      PAT_APOS: return CH_APOS;
      PAT_GT:   return CH_GT;
      PAT_LT:   return CH_LT;
      PAT_QUOT: return CH_QUOT;
      default:  return 8'h00;
    endcase
  endfunction

  // {is digit, value}
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

/* sv/xeu_if.sv */
// valid/ready channel interfaces for input words and result words
`default_nettype none

interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       value_end;
  modport source (output valid, in_byte, value_end, input ready);
  modport sink   (input valid, in_byte, value_end, output ready);
endinterface

interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       done_res;
  logic [1:0] error_code;
  logic       run_last;
  modport source (output valid, out_byte, byte_valid, done_res, error_code, run_last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, done_res, error_code, run_last,
                  output ready);
endinterface

`default_nettype wire

/* sv/xml_entity_unescaper_top.sv */
// top level of the xml entity unescaper: front end, job queue, back end
//
// channel   dir  handshake        payload
// in_ch     in   valid / ready    in_byte[7:0], value_end
// out_ch    out  valid / ready    out_byte[7:0], byte_valid, done_res,
//                                 error_code[1:0], run_last
//
// the front end turns each word into a job of results; the back end emits a job's
// results one a cycle from its output register while out_ch.ready allows, so the
// back end's result rate sets the sustained rate
// a 4-deep job queue lets the front end keep taking words while results drain
// a word's first result passes through the queue, the job register and the output
// register in that order, and a busy back end or a low out_ch.ready can hold it
// rst_n is synchronous; reset returns the decoder to plain text, empties the
// queue and drops out_ch.valid, with no clearing pass
`default_nettype none
`include "xml_entity_unescaper_top_assert.svh"

module xml_entity_unescaper_top (
  input  logic       clk,
  input  logic       rst_n,
  xeu_in_if.sink     in_ch,
  xeu_out_if.source  out_ch
);
  import xeu_pkg::*;

  // jobs from the front end into the queue
  xeu_job_t q_job;
  logic     q_push;
  logic     q_full;

  // jobs from the queue into the back end
  xeu_job_t q_data;
  logic     q_nonempty;
  logic     q_pop;

  // decode state machine, one word per cycle while the queue has room
  xeu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  // words that cause no result push nothing
  xeu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_job),
    .pop      (q_pop),
    .rd_data  (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // serializes each job, marks its final result with run_last
  xeu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

  // a pushed job is never lost from the queue on the next cycle
  `XEU_ASSERT_NEXT(a_push_held, q_push, q_nonempty, "queue empty right after push")
  // every pushed job fits the result slots
  `XEU_ASSERT_NOW(a_job_size, q_push, q_job.cnt <= XEU_CNT_W'(XEU_MAX_RES), "job too large")
  // the done result is always the last result of its word
  `XEU_ASSERT_NOW(a_done_last, out_ch.valid && out_ch.done_res, out_ch.run_last, "done not last")
  // an error result carries no byte
  `XEU_ASSERT_NOW(a_err_nobyte, out_ch.valid && out_ch.error_code != ERR_NONE, !out_ch.byte_valid && out_ch.out_byte == 8'h00, "error result with byte")

endmodule

`default_nettype wire

/* sv/xeu_front.sv */
// front end: decode state machine, turns each input word into a job of results
`default_nettype none

module xeu_front (
  input  logic              clk,
  input  logic              rst_n,
  xeu_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output xeu_pkg::xeu_job_t q_job
);
  import xeu_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN = 3'd0,
    M_AMP   = 3'd1,
    M_NAMED = 3'd2,
    M_HASH  = 3'd3,
    M_HEX   = 3'd4,
    M_DEC   = 3'd5
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  pat_r, pat_nxt;
  logic [7:0]  held_r [4];
  logic [7:0]  held_nxt [4];
  logic [2:0]  cnt_r, cnt_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  xeu_job_t    job;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept && (job.cnt != '0);
  assign q_job       = job;

  always_comb begin
    logic [7:0]           c;
    logic                 fail, plain, num, do_flush, do_clear, to_amp;
    logic [XEU_CNT_W-1:0] n;
    logic [2:0]           p2, hcnt;
    logic [4:0]           dig;
    logic [24:0]          v;
    logic [1:0]           end_err;

    c        = in_ch.in_byte;
    mode_nxt = mode_r;
    pat_nxt  = pat_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    job      = '0;
    n        = '0;
    fail     = 1'b0;
    plain    = 1'b0;
    num      = 1'b0;
    do_flush = 1'b0;
    do_clear = 1'b0;
    to_amp   = 1'b0;
    end_err  = ERR_NONE;
    p2       = pat_r;
    hcnt     = (cnt_r > 3'd4) ? 3'd4 : cnt_r;
    dig      = digit_val(c, mode_r == M_HEX);
    if (mode_r == M_HEX) begin
      v = {acc_r, 4'b0000} + {21'd0, dig[3:0]};
    end else begin
      v = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {21'd0, dig[3:0]};
    end

    if (in_ch.value_end) begin
      case (mode_r)
        M_AMP, M_NAMED:      do_flush = 1'b1;
        M_HASH, M_HEX, M_DEC: end_err = ovf_r ? ERR_RANGE : ERR_NO_SEMI;
        default:             end_err = ERR_NONE;
      endcase
    end else begin
      case (mode_r)
        M_AMP: begin
          case (c)
            CH_A, CH_G, CH_L, CH_Q: begin
              mode_nxt    = M_NAMED;
              pat_nxt     = (c == CH_A) ? PAT_AMP :
                            (c == CH_G) ? PAT_GT  :
                            (c == CH_L) ? PAT_LT  : PAT_QUOT;
              held_nxt[0] = c;
              cnt_nxt     = 3'd1;
            end
            CH_HASH: mode_nxt = M_HASH;
            default: fail = 1'b1;
          endcase
        end
        M_NAMED: begin
          if (cnt_r < 3'd1 || cnt_r > 3'd4 || pat_r > PAT_QUOT) begin
            fail = 1'b1;
          end else begin
            p2 = (pat_r == PAT_AMP && cnt_r == 3'd1 && c == CH_P) ? PAT_APOS : pat_r;
            if (c != pat_text(p2, cnt_r)) begin
              fail = 1'b1;
            end else if (c == CH_SEMI) begin
              job.ent[0] = mk_res(pat_char(p2), 1'b1, 1'b0, ERR_NONE);
              n          = XEU_CNT_W'(1);
              do_clear   = 1'b1;
            end else begin
              pat_nxt = p2;
              if (cnt_r < 3'd4) held_nxt[cnt_r[1:0]] = c;
              cnt_nxt = cnt_r + 3'd1;
            end
          end
        end
        M_HASH: begin
          if (c == CH_X) begin
            mode_nxt = M_HEX;
          end else begin
            mode_nxt = M_DEC;
            num      = 1'b1;
          end
        end
        M_HEX, M_DEC: num = 1'b1;
        default:      plain = 1'b1;
      endcase
    end

    // digit grows the code point; anything else closes the reference
    if (num) begin
      if (dig[4]) begin
        if (ovf_r || v >= CODE_LIMIT) ovf_nxt = 1'b1;
        else acc_nxt = v[20:0];
      end else begin
        do_clear = 1'b1;
        if (ovf_r) begin
          job.ent[0] = mk_res(8'h00, 1'b0, 1'b0, ERR_RANGE);
          n          = XEU_CNT_W'(1);
        end else if (c != CH_SEMI) begin
          job.ent[0] = mk_res(8'h00, 1'b0, 1'b0, ERR_NO_SEMI);
          n          = XEU_CNT_W'(1);
        end else if (acc_r < CP_LIM1) begin
          job.ent[0] = mk_res({1'b0, acc_r[6:0]}, 1'b1, 1'b0, ERR_NONE);
          n          = XEU_CNT_W'(1);
        end else if (acc_r < CP_LIM2) begin
          job.ent[0] = mk_res(UTF8_LEAD2 | {3'b000, acc_r[10:6]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[1] = mk_res(UTF8_CONT | {2'b00, acc_r[5:0]}, 1'b1, 1'b0, ERR_NONE);
          n          = XEU_CNT_W'(2);
        end else if (acc_r < CP_LIM3) begin
          job.ent[0] = mk_res(UTF8_LEAD3 | {4'b0000, acc_r[15:12]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[1] = mk_res(UTF8_CONT | {2'b00, acc_r[11:6]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[2] = mk_res(UTF8_CONT | {2'b00, acc_r[5:0]}, 1'b1, 1'b0, ERR_NONE);
          n          = XEU_CNT_W'(3);
        end else begin
          job.ent[0] = mk_res(UTF8_LEAD4 | {5'b00000, acc_r[20:18]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[1] = mk_res(UTF8_CONT | {2'b00, acc_r[17:12]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[2] = mk_res(UTF8_CONT | {2'b00, acc_r[11:6]}, 1'b1, 1'b0, ERR_NONE);
          job.ent[3] = mk_res(UTF8_CONT | {2'b00, acc_r[5:0]}, 1'b1, 1'b0, ERR_NONE);
          n          = XEU_CNT_W'(4);
        end
      end
    end

    // '&' and the held letters go out unchanged
    if (fail || do_flush) begin
      job.ent[0] = mk_res(CH_AMP, 1'b1, 1'b0, ERR_NONE);
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < hcnt) job.ent[i+1] = mk_res(held_r[i], 1'b1, 1'b0, ERR_NONE);
      end
      n        = XEU_CNT_W'(hcnt) + XEU_CNT_W'(1);
      do_clear = 1'b1;
    end

    // current byte as plain text, or an '&' starts a new reference
    if (fail || plain) begin
      if (c == CH_AMP) begin
        do_clear = 1'b1;
        to_amp   = 1'b1;
      end else begin
        job.ent[n] = mk_res(c, 1'b1, 1'b0, ERR_NONE);
        n          = n + XEU_CNT_W'(1);
      end
    end

    if (in_ch.value_end) begin
      job.ent[n] = mk_res(8'h00, 1'b0, 1'b1, end_err);
      n          = n + XEU_CNT_W'(1);
      do_clear   = 1'b1;
    end

    if (do_clear) begin
      mode_nxt = M_PLAIN;
      pat_nxt  = PAT_AMP;
      cnt_nxt  = 3'd0;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
    end
    if (to_amp) mode_nxt = M_AMP;

    job.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      pat_r  <= PAT_AMP;
      cnt_r  <= 3'd0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pat_r  <= pat_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/xeu_fifo.sv */
// short job queue between front and back end
`default_nettype none

module xeu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xeu_pkg::xeu_job_t wr_data,
  input  logic              pop,
  output xeu_pkg::xeu_job_t rd_data,
  output logic              full,
  output logic              nonempty
);
  import xeu_pkg::*;

  xeu_job_t               mem_r [XEU_QDEPTH];
  logic [XEU_QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [XEU_QCNT_W-1:0]  count_r;

  assign full     = (count_r == XEU_QCNT_W'(XEU_QDEPTH));
  assign nonempty = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + XEU_QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + XEU_QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + XEU_QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - XEU_QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/xeu_back.sv */
// back end: walks a job one result per cycle into the output register while out_ch.ready allows
`default_nettype none

module xeu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xeu_pkg::xeu_job_t q_data,
  input  logic              q_nonempty,
  output logic              q_pop,
  xeu_out_if.source         out_ch
);
  import xeu_pkg::*;

  xeu_job_t             cur_r;
  logic                 cur_valid_r;
  logic [XEU_CNT_W-1:0] idx_r;
  logic                 out_valid_r;
  xeu_res_t             out_res_r;
  logic                 out_last_r;
  logic                 load_ok, emit, is_last;

  assign load_ok = !out_valid_r || out_ch.ready;
  assign emit    = cur_valid_r && load_ok;
  assign is_last = (idx_r == cur_r.cnt - XEU_CNT_W'(1));
  assign q_pop   = q_nonempty && (!cur_valid_r || (emit && is_last));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_res_r.data;
  assign out_ch.byte_valid = out_res_r.byte_ok;
  assign out_ch.done_res   = out_res_r.done;
  assign out_ch.error_code = out_res_r.err;
  assign out_ch.run_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r  <= cur_r.ent[idx_r];
      out_last_r <= is_last;
    end
    if (q_pop) cur_r <= q_data;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load_ok) out_valid_r <= cur_valid_r;
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else begin
        if (emit) idx_r <= idx_r + XEU_CNT_W'(1);
        if (emit && is_last) cur_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
